[design/lkv_pkg.sv]
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key/value cache
// Sizes, codes and the command struct passed to the recency tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  // Store geometry
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
  localparam logic [CAP_W-1:0] CAP_LIMIT  = CAP_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

  // Operation codes
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Command to the recency tracker
  typedef struct packed {
    logic touch;   // make slot the most recent, age the more recent ones
    logic insert;  // place a new entry at slot as the most recent
    logic evict;   // insert reuses a valid slot, count stays
    idx_t slot;
  } rec_op_t;

endpackage

`default_nettype wire

[design/lkv_kv_mem.sv]
// ----------------------------------------------------------------------------
// lkv_kv_mem: key and value storage
// One shared read address with registered read data, one write address with
// separate enables for the key and the value array.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_kv_mem (
  input  wire logic                     clk_i,
  input  wire lkv_pkg::idx_t            rd_addr_i,
  input  wire lkv_pkg::idx_t            wr_addr_i,
  input  wire logic                     wr_key_en_i,
  input  wire logic                     wr_val_en_i,
  input  wire logic [lkv_pkg::KEY_W-1:0] wr_key_i,
  input  wire logic [lkv_pkg::VAL_W-1:0] wr_val_i,
  output logic      [lkv_pkg::KEY_W-1:0] rd_key_o,
  output logic      [lkv_pkg::VAL_W-1:0] rd_val_o
);

  logic [lkv_pkg::KEY_W-1:0] key_mem [lkv_pkg::MAX_ENTRIES];
  logic [lkv_pkg::VAL_W-1:0] val_mem [lkv_pkg::MAX_ENTRIES];

  // Write ports
  always_ff @(posedge clk_i) begin
    if (wr_key_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (wr_val_en_i) begin
      val_mem[wr_addr_i] <= wr_val_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rd_key_o <= key_mem[rd_addr_i];
    rd_val_o <= val_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

[design/lkv_recency.sv]
// ----------------------------------------------------------------------------
// lkv_recency: valid bits, recency ranks and entry count
// Rank 0 is the most recent entry. Applies touch and insert commands and
// offers one probe port for the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_recency (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lkv_pkg::rec_op_t op_i,
  input  wire lkv_pkg::idx_t    probe_idx_i,
  output logic                  probe_valid_o,
  output lkv_pkg::idx_t         probe_rank_o,
  output lkv_pkg::cnt_t         count_o
);

  logic [lkv_pkg::MAX_ENTRIES-1:0] valid_q;
  lkv_pkg::idx_t                   rank_q [lkv_pkg::MAX_ENTRIES];
  lkv_pkg::cnt_t                   count_q;

  // Apply recency commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (op_i.touch) begin
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
        if (valid_q[i] && (rank_q[i] < rank_q[op_i.slot])) begin
          rank_q[i] <= rank_q[i] + lkv_pkg::idx_t'(1);
        end
      end
      rank_q[op_i.slot] <= '0;
    end else if (op_i.insert) begin
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
        if (valid_q[i] && (lkv_pkg::idx_t'(i) != op_i.slot)) begin
          rank_q[i] <= rank_q[i] + lkv_pkg::idx_t'(1);
        end
      end
      rank_q[op_i.slot]  <= '0;
      valid_q[op_i.slot] <= 1'b1;
      if (!op_i.evict) begin
        count_q <= count_q + lkv_pkg::CNT_ONE;
      end
    end
  end

  assign probe_valid_o = valid_q[probe_idx_i];
  assign probe_rank_o  = rank_q[probe_idx_i];
  assign count_o       = count_q;

`ifndef SYNTH
  // Count tracks the number of valid entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(valid_q))
    else $error("entry count differs from valid bits");

  // A touched or inserted slot becomes the most recent valid entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i.touch || op_i.insert) |=> (rank_q[$past(op_i.slot)] == '0)
      && valid_q[$past(op_i.slot)])
    else $error("slot not most recent after update");

  // Never two commands at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(op_i.touch && op_i.insert))
    else $error("touch and insert together");
`endif

endmodule

`default_nettype wire

[design/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value store, LRU replacement
// A get hit or an eviction adds the fetch state to read the value or the
//   victim key. A new item is taken once the last result is in the output
//   register. The single key comparator scans the sixteen entries one per
//   cycle through the registered read.
// Reset: asynchronous, active low; the store starts empty, capacity is 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration: capacity
  input  wire logic                          cfg_we_i,
  input  wire logic [lkv_pkg::CAP_W-1:0]     cfg_wdata_i,
  // Input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [63:0]                   s_axis_tdata,  // key, write_value
  input  wire logic                          s_axis_tuser,  // mode
  // Result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [63:0]                   m_axis_tdata,  // read_value, evicted_key
  output logic      [1:0]                    m_axis_tuser   // found, evicted
);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_q, state_d;

  logic [lkv_pkg::CAP_W-1:0] cap_q;
  lkv_pkg::cnt_t             cap_eff;

  // Item registers
  logic                      mode_q;
  logic [lkv_pkg::KEY_W-1:0] key_q;
  logic [lkv_pkg::VAL_W-1:0] wval_q;

  // Scan control
  lkv_pkg::idx_t idx_q;
  logic          issue_q;
  logic          cmp_vld_q;
  lkv_pkg::idx_t cmp_idx_q;

  // Scan results
  logic          hit_q;
  lkv_pkg::idx_t hit_idx_q;
  logic          free_q;
  lkv_pkg::idx_t free_idx_q;
  logic          old_q;
  lkv_pkg::idx_t old_idx_q;
  lkv_pkg::idx_t old_rank_q;

  // Pending result
  logic                      res_load;
  logic                      res_found_d, res_ev_d;
  logic [lkv_pkg::VAL_W-1:0] res_rd_d;
  logic [lkv_pkg::KEY_W-1:0] res_evk_d;
  logic                      res_found_q, res_ev_q;
  logic [lkv_pkg::VAL_W-1:0] res_rd_q;
  logic [lkv_pkg::KEY_W-1:0] res_evk_q;

  // Output register
  logic                      out_valid_q;
  logic                      out_found_q, out_ev_q;
  logic [lkv_pkg::VAL_W-1:0] out_rd_q;
  logic [lkv_pkg::KEY_W-1:0] out_evk_q;

  // Memory and tracker connections
  lkv_pkg::idx_t             rd_addr, wr_addr;
  logic                      wr_key_en, wr_val_en;
  logic [lkv_pkg::KEY_W-1:0] rd_key;
  logic [lkv_pkg::VAL_W-1:0] rd_val;
  lkv_pkg::rec_op_t          rec_op;
  logic                      probe_valid;
  lkv_pkg::idx_t             probe_rank;
  lkv_pkg::cnt_t             count;

  logic in_xfer, out_xfer, out_free, key_match;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Clamp capacity into 1..MAX_ENTRIES
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = lkv_pkg::CNT_ONE;
    end else if (cap_q >= lkv_pkg::CAP_LIMIT) begin
      cap_eff = lkv_pkg::CNT_MAX;
    end else begin
      cap_eff = lkv_pkg::cnt_t'(cap_q);
    end
  end

  // Shared key comparator
  assign key_match = probe_valid && (rd_key == key_q);

  // Sequencer decisions
  always_comb begin
    state_d     = state_q;
    rd_addr     = idx_q;
    wr_addr     = hit_idx_q;
    wr_key_en   = 1'b0;
    wr_val_en   = 1'b0;
    rec_op      = '0;
    res_load    = 1'b0;
    res_found_d = hit_q;
    res_rd_d    = '0;
    res_ev_d    = 1'b0;
    res_evk_d   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmp_vld_q && (cmp_idx_q == lkv_pkg::IDX_LAST)) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (mode_q == lkv_pkg::MODE_GET) begin
          if (hit_q) begin
            rd_addr = hit_idx_q;
            state_d = S_FETCH;
          end else begin
            res_load = 1'b1;
            res_rd_d = lkv_pkg::MISS_VALUE;
            state_d  = S_DONE;
          end
        end else if (hit_q) begin
          // Overwrite value of the present key
          wr_val_en     = 1'b1;
          rec_op.touch  = 1'b1;
          rec_op.slot   = hit_idx_q;
          res_load      = 1'b1;
          state_d       = S_DONE;
        end else if ((count < cap_eff) && free_q) begin
          // Fill a free slot
          wr_addr       = free_idx_q;
          wr_key_en     = 1'b1;
          wr_val_en     = 1'b1;
          rec_op.insert = 1'b1;
          rec_op.slot   = free_idx_q;
          res_load      = 1'b1;
          state_d       = S_DONE;
        end else if (old_q) begin
          rd_addr = old_idx_q;
          state_d = S_FETCH;
        end else begin
          res_load = 1'b1;
          state_d  = S_DONE;
        end
      end
      S_FETCH: begin
        res_load = 1'b1;
        if (mode_q == lkv_pkg::MODE_GET) begin
          rec_op.touch = 1'b1;
          rec_op.slot  = hit_idx_q;
          res_rd_d     = rd_val;
        end else begin
          // Evict the least recent entry and reuse its slot
          wr_addr       = old_idx_q;
          wr_key_en     = 1'b1;
          wr_val_en     = 1'b1;
          rec_op.insert = 1'b1;
          rec_op.evict  = 1'b1;
          rec_op.slot   = old_idx_q;
          res_ev_d      = 1'b1;
          res_evk_d     = rd_key;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= lkv_pkg::CAP_RESET;
      issue_q     <= 1'b0;
      cmp_vld_q   <= 1'b0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      old_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      // Start a scan on transfer
      if (in_xfer) begin
        idx_q     <= '0;
        issue_q   <= 1'b1;
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
        free_q    <= 1'b0;
        old_q     <= 1'b0;
      end else if (state_q == S_SCAN) begin
        cmp_vld_q <= issue_q;
        if (issue_q) begin
          if (idx_q == lkv_pkg::IDX_LAST) begin
            issue_q <= 1'b0;
          end else begin
            idx_q <= idx_q + lkv_pkg::idx_t'(1);
          end
        end
        if (cmp_vld_q) begin
          if (key_match && !hit_q) begin
            hit_q <= 1'b1;
          end
          if (!probe_valid && !free_q) begin
            free_q <= 1'b1;
          end
          if (probe_valid && (!old_q || (probe_rank > old_rank_q))) begin
            old_q <= 1'b1;
          end
        end
      end
      // Output register: load from pending result, drop on transfer
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q <= s_axis_tuser;
      key_q  <= s_axis_tdata[31:0];
      wval_q <= s_axis_tdata[63:32];
    end
    if ((state_q == S_SCAN) && issue_q) begin
      cmp_idx_q <= idx_q;
    end
    if ((state_q == S_SCAN) && cmp_vld_q) begin
      if (key_match && !hit_q) begin
        hit_idx_q <= cmp_idx_q;
      end
      if (!probe_valid && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
      if (probe_valid && (!old_q || (probe_rank > old_rank_q))) begin
        old_idx_q  <= cmp_idx_q;
        old_rank_q <= probe_rank;
      end
    end
    if (res_load) begin
      res_found_q <= res_found_d;
      res_rd_q    <= res_rd_d;
      res_ev_q    <= res_ev_d;
      res_evk_q   <= res_evk_d;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_found_q <= res_found_q;
      out_rd_q    <= res_rd_q;
      out_ev_q    <= res_ev_q;
      out_evk_q   <= res_evk_q;
    end
  end

  lkv_kv_mem u_mem (
    .clk_i       (clk_i),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .wr_key_en_i (wr_key_en),
    .wr_val_en_i (wr_val_en),
    .wr_key_i    (key_q),
    .wr_val_i    (wval_q),
    .rd_key_o    (rd_key),
    .rd_val_o    (rd_val)
  );

  lkv_recency u_recency (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (rec_op),
    .probe_idx_i   (cmp_idx_q),
    .probe_valid_o (probe_valid),
    .probe_rank_o  (probe_rank),
    .count_o       (count)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_evk_q, out_rd_q};
  assign m_axis_tuser  = {out_ev_q, out_found_q};

`ifndef SYNTH
  // A hit and an eviction exclude each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_found_q && out_ev_q))
    else $error("result both found and evicted");

  // No evicted key without an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ev_q) |-> (out_evk_q == '0))
    else $error("evicted key set without eviction");

  // Scan runs to the last entry before a decision
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> ($past(cmp_idx_q) == lkv_pkg::IDX_LAST) && !issue_q)
    else $error("decision before scan finished");

  // Store never holds more entries than it has slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= lkv_pkg::CNT_MAX)
    else $error("entry count overflow");
`endif

endmodule

`default_nettype wire
